// ===== rtl/core/cmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cmf_pkg
// shared constants and types of the cross median filter
// ----------------------------------------------------------------------------
package cmf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WIDTH_RESET   = 640;
  localparam int CFG_W         = 11;
  localparam int PIX_W         = 8;
  localparam int SEEN_W        = 13;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // neighbour selection and marker that travel with one item
  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic up_ok;
    logic down_ok;
    logic frame_done;
  } cmf_tag_t;

endpackage
`default_nettype wire

// ===== rtl/core/cmf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cmf_ctrl
// stride register, frame counters and line store address generation
// ----------------------------------------------------------------------------
module cmf_ctrl #(
  parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF,
  parameter int AW        = $clog2(6 * MAX_WIDTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [cmf_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                     in_acc,
  input  wire logic                     in_action,
  input  wire logic                     in_frame_start,
  output logic                          we,
  output logic [AW-1:0]                 wa,
  output logic                          rd_en,
  output logic [AW-1:0]                 ca,
  output logic [AW-1:0]                 ra,
  output logic [AW-1:0]                 ua,
  output logic [AW-1:0]                 da,
  output cmf_pkg::cmf_tag_t             tag
);
  import cmf_pkg::*;

  localparam int STRIDE_MAX = 3 * MAX_WIDTH;
  localparam int DEPTH      = 6 * MAX_WIDTH + 1;
  localparam int SW         = $clog2(STRIDE_MAX + 1);
  localparam int PW         = $clog2(STRIDE_MAX + 2);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int CW         = ((PW > SEEN_W) ? PW : SEEN_W) + 1;
  localparam int RST_W      = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam logic [SW-1:0] STRIDE_RESET = SW'(3 * RST_W);
  localparam logic [AW:0]   DEPTH_X      = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR    = AW'(DEPTH - 1);

  logic [SW-1:0]     stride_r, stride_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [PW-1:0]     pend_r, pend_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;

  logic [WW-1:0]     w_c;
  logic              push;
  logic [SEEN_W-1:0] seen0, cur_seen;
  logic [PW-1:0]     pend0, cur_pend, off;
  logic              emit;
  logic [AW-1:0]     wp_inc, wp_dec, base;
  logic [CW-1:0]     pos;
  logic              pos_neg;
  logic [AW-1:0]     off_a, s_a;

  function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] b,
                                             input logic [AW-1:0] k);
    logic [AW:0] d;
    d = {1'b0, b} - {1'b0, k};
    if (d[AW]) begin
      wrap_sub = AW'(d + DEPTH_X);
    end else begin
      wrap_sub = d[AW-1:0];
    end
  endfunction

  // clamp the width and form the stride
  always_comb begin
    if (cfg_data == '0) begin
      w_c = WW'(1);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(cfg_data);
    end
    stride_nxt = cfg_we ? (SW'({w_c, 1'b0}) + SW'(w_c)) : stride_r;
  end

  always_comb begin
    push    = (in_action == ACT_PUSH);
    seen0   = (push && in_frame_start) ? '0 : seen_r;
    pend0   = (push && in_frame_start) ? '0 : pend_r;
    wp_inc  = (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
    wp_dec  = (wp_r == '0) ? LAST_ADDR : wp_r - AW'(1);

    if (push) begin
      cur_seen = (seen0 == SEEN_MAX) ? seen0 : seen0 + SEEN_W'(1);
      cur_pend = pend0 + PW'(1);
      emit     = (cur_pend > PW'(stride_r));
      base     = wp_r;
    end else begin
      cur_seen = seen_r;
      cur_pend = pend_r;
      emit     = (pend_r != '0);
      base     = wp_dec;
    end

    off     = cur_pend - PW'(1);
    pos     = CW'(cur_seen) - CW'(cur_pend);
    pos_neg = pos[CW-1];
    off_a   = AW'(off);
    s_a     = AW'(stride_r);

    tag.left_ok    = pos_neg || (pos >= CW'(3));
    tag.up_ok      = pos_neg || (pos >= CW'(stride_r));
    tag.right_ok   = (off >= PW'(3));
    tag.down_ok    = (off >= PW'(stride_r));
    tag.frame_done = !push && (pend_r == PW'(1));

    ca = wrap_sub(base, off_a);
    ra = wrap_sub(base, off_a - AW'(3));
    ua = wrap_sub(base, off_a + s_a);
    da = wrap_sub(base, off_a - s_a);

    we    = in_acc && push;
    wa    = wp_r;
    rd_en = in_acc && emit;

    seen_nxt = in_acc ? cur_seen : seen_r;
    wp_nxt   = (in_acc && push) ? wp_inc : wp_r;
    if (in_acc) begin
      pend_nxt = emit ? cur_pend - PW'(1) : cur_pend;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RESET;
      seen_r   <= '0;
      pend_r   <= '0;
      wp_r     <= '0;
    end else begin
      stride_r <= stride_nxt;
      seen_r   <= seen_nxt;
      pend_r   <= pend_nxt;
      wp_r     <= wp_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cmf_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cmf_store
// two copies of the line store, each with one write and two read ports,
// plus forwarding of a sample written in the same cycle as it is read
// ----------------------------------------------------------------------------
module cmf_store #(
  parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF,
  parameter int AW        = $clog2(6 * MAX_WIDTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             wa,
  input  wire logic [cmf_pkg::PIX_W-1:0] wd,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             ca,
  input  wire logic [AW-1:0]             ra,
  input  wire logic [AW-1:0]             ua,
  input  wire logic [AW-1:0]             da,
  output logic [cmf_pkg::PIX_W-1:0]      c_val,
  output logic [cmf_pkg::PIX_W-1:0]      r_val,
  output logic [cmf_pkg::PIX_W-1:0]      u_val,
  output logic [cmf_pkg::PIX_W-1:0]      d_val
);
  import cmf_pkg::*;

  localparam int DEPTH = 6 * MAX_WIDTH + 1;

  logic [PIX_W-1:0] mem_a [DEPTH];
  logic [PIX_W-1:0] mem_b [DEPTH];

  logic [PIX_W-1:0] c_q_r, r_q_r, u_q_r, d_q_r, wd_r;
  logic [3:0]       fwd_r, fwd_nxt;

  always_comb begin
    fwd_nxt[0] = we && (ca == wa);
    fwd_nxt[1] = we && (ra == wa);
    fwd_nxt[2] = we && (ua == wa);
    fwd_nxt[3] = we && (da == wa);
  end

  // read before write: a same-address read returns the old word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      c_q_r <= mem_a[ca];
      r_q_r <= mem_a[ra];
    end
    if (we) begin
      mem_a[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      u_q_r <= mem_b[ua];
      d_q_r <= mem_b[da];
    end
    if (we) begin
      mem_b[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= '0;
    end else if (rd_en) begin
      fwd_r <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      wd_r <= wd;
    end
  end

  assign c_val = fwd_r[0] ? wd_r : c_q_r;
  assign r_val = fwd_r[1] ? wd_r : r_q_r;
  assign u_val = fwd_r[2] ? wd_r : u_q_r;
  assign d_val = fwd_r[3] ? wd_r : d_q_r;

endmodule
`default_nettype wire

// ===== rtl/core/cmf_median.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cmf_median
// left neighbour history, five input sorting network, median select and
// output register
// ----------------------------------------------------------------------------
module cmf_median (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire cmf_pkg::cmf_tag_t         tag_in,
  input  wire logic [cmf_pkg::PIX_W-1:0] c_val,
  input  wire logic [cmf_pkg::PIX_W-1:0] r_val,
  input  wire logic [cmf_pkg::PIX_W-1:0] u_val,
  input  wire logic [cmf_pkg::PIX_W-1:0] d_val,
  output logic                           ready,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [cmf_pkg::PIX_W-1:0]      out_filtered_value,
  output logic                           out_frame_done
);
  import cmf_pkg::*;

  localparam int NCE = 9;
  localparam int CE_LO [NCE] = '{0, 1, 0, 1, 0, 2, 1, 3, 2};
  localparam int CE_HI [NCE] = '{3, 4, 2, 3, 1, 4, 2, 4, 3};
  localparam logic [PIX_W-1:0] PAD = '1;

  logic             s1_v_r, s1_v_nxt;
  cmf_tag_t         tag_r;
  logic [PIX_W-1:0] hist_r [3];
  logic             out_valid_r;
  logic [PIX_W-1:0] out_value_r;
  logic             out_done_r;
  logic             adv, move;

  logic [PIX_W-1:0] s [5];
  logic [PIX_W-1:0] t;
  logic [2:0]       n;
  logic [PIX_W:0]   sum_lo, sum_hi;
  logic [PIX_W-1:0] med;

  assign adv   = !out_valid_r || !out_stall;
  assign move  = s1_v_r && adv;
  assign ready = !s1_v_r || adv;

  always_comb begin
    s[0] = c_val;
    s[1] = tag_r.left_ok  ? hist_r[2] : PAD;
    s[2] = tag_r.right_ok ? r_val     : PAD;
    s[3] = tag_r.up_ok    ? u_val     : PAD;
    s[4] = tag_r.down_ok  ? d_val     : PAD;
    t    = '0;
    for (int i = 0; i < NCE; i++) begin
      if (s[CE_LO[i]] > s[CE_HI[i]]) begin
        t            = s[CE_LO[i]];
        s[CE_LO[i]]  = s[CE_HI[i]];
        s[CE_HI[i]]  = t;
      end
    end
    n = 3'd1 + 3'(tag_r.left_ok) + 3'(tag_r.right_ok) + 3'(tag_r.up_ok)
      + 3'(tag_r.down_ok);
    sum_lo = {1'b0, s[0]} + {1'b0, s[1]};
    sum_hi = {1'b0, s[1]} + {1'b0, s[2]};
    case (n)
      3'd1:    med = s[0];
      3'd2:    med = sum_lo[PIX_W:1];
      3'd3:    med = s[1];
      3'd4:    med = sum_hi[PIX_W:1];
      default: med = s[2];
    endcase
  end

  always_comb begin
    if (load) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag_r <= tag_in;
    end
    if (move) begin
      out_value_r <= med;
      out_done_r  <= tag_r.frame_done;
      hist_r[0]   <= c_val;
      hist_r[1]   <= hist_r[0];
      hist_r[2]   <= hist_r[1];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;
  assign out_frame_done     = out_done_r;

endmodule
`default_nettype wire

// ===== rtl/core/cross_median_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cross_median_filter
// five point cross median filter over one interleaved rgb layer
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless stalled. Results pass the store read
// registers and the output register; pushes emit once one row of samples is
// pending, flushes drain the rest. The rate is set by the line store: two
// copies, each with one write and two read ports, fetch a sample and its
// three stored neighbours, and the left neighbour comes from a three deep
// history of earlier centre samples. No clearing pass follows reset. The user
// must write width through the cfg port only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module cross_median_filter #(
  parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_action,
  input  wire logic [cmf_pkg::PIX_W-1:0] in_sample_value,
  input  wire logic                      in_frame_start,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [cmf_pkg::PIX_W-1:0]      out_filtered_value,
  output logic                           out_frame_done,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [cmf_pkg::CFG_W-1:0] cfg_data
);
  import cmf_pkg::*;

  localparam int AW = $clog2(6 * MAX_WIDTH + 1);

  logic             in_acc, ready;
  logic             we, rd_en;
  logic [AW-1:0]    wa, ca, ra, ua, da;
  logic [PIX_W-1:0] c_val, r_val, u_val, d_val;
  cmf_tag_t         tag;

  assign cfg_ready = 1'b1;
  assign in_stall  = !ready;
  assign in_acc    = in_valid && ready;

  cmf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .in_acc         (in_acc),
    .in_action      (in_action),
    .in_frame_start (in_frame_start),
    .we             (we),
    .wa             (wa),
    .rd_en          (rd_en),
    .ca             (ca),
    .ra             (ra),
    .ua             (ua),
    .da             (da),
    .tag            (tag)
  );

  cmf_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .wa    (wa),
    .wd    (in_sample_value),
    .rd_en (rd_en),
    .ca    (ca),
    .ra    (ra),
    .ua    (ua),
    .da    (da),
    .c_val (c_val),
    .r_val (r_val),
    .u_val (u_val),
    .d_val (d_val)
  );

  cmf_median u_median (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (rd_en),
    .tag_in             (tag),
    .c_val              (c_val),
    .r_val              (r_val),
    .u_val              (u_val),
    .d_val              (d_val),
    .ready              (ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_value (out_filtered_value),
    .out_frame_done     (out_frame_done)
  );

endmodule
`default_nettype wire
